[src/dataflash_command_framer_defines.svh]
// Assertion macros shared by the command framer modules.
`ifndef DATAFLASH_COMMAND_FRAMER_DEFINES_SVH
`define DATAFLASH_COMMAND_FRAMER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, disabled while reset is asserted.
`define DCF_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("dcf assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define DCF_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("dcf assertion failed");

`else

`define DCF_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define DCF_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

[src/dcf_pkg.sv]
`timescale 1ns / 1ps
package dcf_pkg;

  typedef enum logic [2:0] {
    REQ_PAGE_TO_BUF  = 3'd0,
    REQ_BUF_TO_PAGE  = 3'd1,
    REQ_PAGE_ERASE   = 3'd2,
    REQ_BLOCK_ERASE  = 3'd3,
    REQ_BUF_WRITE    = 3'd4,
    REQ_BUF_READ     = 3'd5
  } dcf_req_e;

  localparam logic [7:0] OP_PAGE_TO_BUF1 = 8'h53;
  localparam logic [7:0] OP_PAGE_TO_BUF2 = 8'h55;
  localparam logic [7:0] OP_BUF1_TO_PAGE = 8'h83;
  localparam logic [7:0] OP_BUF2_TO_PAGE = 8'h86;
  localparam logic [7:0] OP_PAGE_ERASE   = 8'h81;
  localparam logic [7:0] OP_BLOCK_ERASE  = 8'h50;
  localparam logic [7:0] OP_BUF1_WRITE   = 8'h84;
  localparam logic [7:0] OP_BUF2_WRITE   = 8'h87;
  localparam logic [7:0] OP_BUF1_READ    = 8'hD4;
  localparam logic [7:0] OP_BUF2_READ    = 8'hD6;
  localparam logic [7:0] PAD_BYTE        = 8'h00;

  localparam int unsigned MaxFrameBytes = 6;
  localparam int unsigned IdxW          = 3;

  // One complete command frame as handed from the front end to the back end.
  typedef struct packed {
    logic [MaxFrameBytes-1:0][7:0] bytes;
    logic [IdxW-1:0]               last_idx;
    logic                          poll;
    logic                          capture;
  } dcf_frame_t;

endpackage

[src/dcf_front.sv]
`timescale 1ns / 1ps
`include "dataflash_command_framer_defines.svh"
module dcf_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [2:0]          req_type_i,
  input  logic                buffer_select_i,
  input  logic [12:0]         address_i,
  input  logic [7:0]          write_data_i,
  input  logic                wait_after_i,
  output logic                frame_valid_o,
  input  logic                frame_ready_i,
  output dcf_pkg::dcf_frame_t frame_o
);

  logic                page512_q;
  logic                frame_valid_q, frame_valid_d;
  dcf_pkg::dcf_frame_t frame_q;
  dcf_pkg::dcf_frame_t frame_build;
  logic                legal;
  logic                accept;
  logic [7:0]          page_hi;
  logic [7:0]          page_lo;
  logic [7:0]          off_hi;

  assign in_ready_o    = !frame_valid_q || frame_ready_i;
  assign accept        = in_valid_i && in_ready_o;
  assign frame_valid_o = frame_valid_q;
  assign frame_o       = frame_q;

  // Page addresses straddle two bytes; the split depends on the page size.
  always_comb begin
    if (page512_q) begin
      page_hi = {2'b00, address_i[12:7]};
      page_lo = {address_i[6:0], 1'b0};
    end else begin
      page_hi = {1'b0, address_i[12:6]};
      page_lo = {address_i[5:0], 2'b00};
    end
    off_hi = {3'b000, address_i[12:8]};
  end

  always_comb begin
    legal                = 1'b1;
    frame_build.bytes    = '0;
    frame_build.last_idx = dcf_pkg::IdxW'(3);
    frame_build.poll     = 1'b1;
    frame_build.capture  = 1'b0;
    frame_build.bytes[1] = page_hi;
    frame_build.bytes[2] = page_lo;
    frame_build.bytes[3] = dcf_pkg::PAD_BYTE;
    case (req_type_i)
      dcf_pkg::REQ_PAGE_TO_BUF: begin
        frame_build.bytes[0] = buffer_select_i ? dcf_pkg::OP_PAGE_TO_BUF2
                                               : dcf_pkg::OP_PAGE_TO_BUF1;
      end
      dcf_pkg::REQ_BUF_TO_PAGE: begin
        frame_build.bytes[0] = buffer_select_i ? dcf_pkg::OP_BUF2_TO_PAGE
                                               : dcf_pkg::OP_BUF1_TO_PAGE;
        frame_build.poll     = wait_after_i;
      end
      dcf_pkg::REQ_PAGE_ERASE: begin
        frame_build.bytes[0] = dcf_pkg::OP_PAGE_ERASE;
      end
      dcf_pkg::REQ_BLOCK_ERASE: begin
        frame_build.bytes[0] = dcf_pkg::OP_BLOCK_ERASE;
      end
      dcf_pkg::REQ_BUF_WRITE: begin
        frame_build.bytes[0] = buffer_select_i ? dcf_pkg::OP_BUF2_WRITE
                                               : dcf_pkg::OP_BUF1_WRITE;
        frame_build.bytes[1] = dcf_pkg::PAD_BYTE;
        frame_build.bytes[2] = off_hi;
        frame_build.bytes[3] = address_i[7:0];
        frame_build.bytes[4] = write_data_i;
        frame_build.last_idx = dcf_pkg::IdxW'(4);
        frame_build.poll     = 1'b0;
      end
      dcf_pkg::REQ_BUF_READ: begin
        frame_build.bytes[0] = buffer_select_i ? dcf_pkg::OP_BUF2_READ
                                               : dcf_pkg::OP_BUF1_READ;
        frame_build.bytes[1] = dcf_pkg::PAD_BYTE;
        frame_build.bytes[2] = off_hi;
        frame_build.bytes[3] = address_i[7:0];
        frame_build.bytes[4] = dcf_pkg::PAD_BYTE;
        frame_build.bytes[5] = dcf_pkg::PAD_BYTE;
        frame_build.last_idx = dcf_pkg::IdxW'(5);
        frame_build.poll     = 1'b0;
        frame_build.capture  = 1'b1;
      end
      default: begin
        // Undefined request codes are taken and dropped without a frame.
        legal = 1'b0;
      end
    endcase
  end

  always_comb begin
    frame_valid_d = frame_valid_q && !frame_ready_i;
    if (accept) begin
      frame_valid_d = legal;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page512_q     <= 1'b0;
      frame_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        page512_q <= cfg_data_i;
      end
      frame_valid_q <= frame_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      frame_q <= frame_build;
    end
  end

  `DCF_ASSERT_NXT(a_front_hold, clk_i, rst_ni, frame_valid_q && !frame_ready_i, frame_valid_q)
  `DCF_ASSERT_NXT(a_front_stable, clk_i, rst_ni, frame_valid_q && !frame_ready_i, $stable(frame_q))

endmodule

[src/dcf_fifo.sv]
`timescale 1ns / 1ps
`include "dataflash_command_framer_defines.svh"
module dcf_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_valid_i,
  output logic                push_ready_o,
  input  dcf_pkg::dcf_frame_t push_data_i,
  output logic                pop_valid_o,
  input  logic                pop_ready_i,
  output dcf_pkg::dcf_frame_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  dcf_pkg::dcf_frame_t mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     count_q, count_d;
  logic                push;
  logic                pop;

  assign push_ready_o = (count_q != CntW'(Depth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  `DCF_ASSERT_IMP(a_fifo_bound, clk_i, rst_ni, 1'b1, count_q <= CntW'(Depth))

endmodule

[src/dcf_back.sv]
`timescale 1ns / 1ps
`include "dataflash_command_framer_defines.svh"
module dcf_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                frame_valid_i,
  output logic                frame_ready_o,
  input  dcf_pkg::dcf_frame_t frame_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          tx_byte_o,
  output logic                capture_rx_o,
  output logic                poll_busy_o,
  output logic                last_byte_o
);

  dcf_pkg::dcf_frame_t         cur_q;
  logic                        cur_valid_q, cur_valid_d;
  logic [dcf_pkg::IdxW-1:0]    idx_q, idx_d;
  logic                        out_valid_q, out_valid_d;
  logic [7:0]                  tx_q;
  logic                        cap_q, poll_q, last_q;
  logic                        advance;
  logic                        at_last;
  logic                        load;

  // The output word register frees up whenever the sink takes its word.
  assign advance       = !out_valid_q || out_ready_i;
  assign at_last       = (idx_q == cur_q.last_idx);
  assign frame_ready_o = !cur_valid_q || (advance && at_last);
  assign load          = frame_valid_i && frame_ready_o;

  assign out_valid_o  = out_valid_q;
  assign tx_byte_o    = tx_q;
  assign capture_rx_o = cap_q;
  assign poll_busy_o  = poll_q;
  assign last_byte_o  = last_q;

  always_comb begin
    cur_valid_d = cur_valid_q;
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = cur_valid_q;
      if (cur_valid_q) begin
        if (at_last) begin
          cur_valid_d = 1'b0;
        end else begin
          idx_d = idx_q + dcf_pkg::IdxW'(1);
        end
      end
    end
    if (load) begin
      cur_valid_d = 1'b1;
      idx_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cur_valid_q <= cur_valid_d;
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= frame_i;
    end
    if (advance && cur_valid_q) begin
      tx_q   <= cur_q.bytes[idx_q];
      last_q <= at_last;
      poll_q <= at_last && cur_q.poll;
      cap_q  <= at_last && cur_q.capture;
    end
  end

  `DCF_ASSERT_IMP(a_back_poll_last, clk_i, rst_ni, out_valid_q && poll_q, last_q)
  `DCF_ASSERT_IMP(a_back_cap_last, clk_i, rst_ni, out_valid_q && cap_q, last_q)
  `DCF_ASSERT_IMP(a_back_idx_range, clk_i, rst_ni, cur_valid_q, idx_q <= cur_q.last_idx)

endmodule

[src/dataflash_command_framer.sv]
`timescale 1ns / 1ps
// Serial-flash command framer. Each request word becomes a frame of four to six
// output words, one per frame byte: page transfers and erases give four, a buffer
// write five and a buffer read six. The back end sends one byte per clock while
// the sink keeps ready high and a frame is queued, and frames follow one another
// with no gap; the single byte output register of the back end sets that rate.
// The front end registers and classifies requests into a short frame queue, so
// new requests are taken while earlier frames are still going out. Undefined
// request codes are accepted and give no output. The page size register may be
// written only while the block is idle.
module dataflash_command_framer #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  req_type_i,
  input  logic        buffer_select_i,
  input  logic [12:0] address_i,
  input  logic [7:0]  write_data_i,
  input  logic        wait_after_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  tx_byte_o,
  output logic        capture_rx_o,
  output logic        poll_busy_o,
  output logic        last_byte_o
);

  dcf_pkg::dcf_frame_t front_frame;
  dcf_pkg::dcf_frame_t queue_frame;
  logic                front_valid, front_ready;
  logic                queue_valid, queue_ready;

  dcf_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .buffer_select_i (buffer_select_i),
    .address_i       (address_i),
    .write_data_i    (write_data_i),
    .wait_after_i    (wait_after_i),
    .frame_valid_o   (front_valid),
    .frame_ready_i   (front_ready),
    .frame_o         (front_frame)
  );

  dcf_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_data_i  (front_frame),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_data_o   (queue_frame)
  );

  dcf_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (queue_valid),
    .frame_ready_o (queue_ready),
    .frame_i       (queue_frame),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .tx_byte_o     (tx_byte_o),
    .capture_rx_o  (capture_rx_o),
    .poll_busy_o   (poll_busy_o),
    .last_byte_o   (last_byte_o)
  );

endmodule
